### rtl/core/point_affine_transform_3d_assert.svh
// assertion macros for the point transform block
`ifndef POINT_AFFINE_TRANSFORM_3D_ASSERT_SVH
`define POINT_AFFINE_TRANSFORM_3D_ASSERT_SVH

`ifndef SYNTHESIS
`define PAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PAT_ASSERT(lbl, prop, msg)
`define PAT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/core/pat3d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pat3d_pkg;

  localparam int COORD_W      = 32;
  localparam int VEC_W        = 36;
  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_STEPS = 25;
  localparam int ANG_FRAC     = 24;
  localparam int XY_W         = 34;
  localparam int ANG_W        = 36;
  localparam int REG_IDX_W    = 3;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [REG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PARAM_X  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PARAM_Y  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PARAM_Z  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_X = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Z = 3'd6;

  typedef enum logic [1:0] {
    MODE_TRANSLATE = 2'd0,
    MODE_SCALE     = 2'd1,
    MODE_ROTATE    = 2'd2,
    MODE_PASS      = 2'd3
  } mode_e;

  typedef logic signed [VEC_W-1:0] vec_t;

  // arctangent of 2^-i in degrees, 24 fraction bits
  function automatic logic signed [ANG_W-1:0] atan_deg(input logic [4:0] i);
    logic signed [ANG_W-1:0] v;
    unique case (i)
      5'd0:  v = 36'sd754974720;
      5'd1:  v = 36'sd445687602;
      5'd2:  v = 36'sd235489088;
      5'd3:  v = 36'sd119537938;
      5'd4:  v = 36'sd60000934;
      5'd5:  v = 36'sd30029717;
      5'd6:  v = 36'sd15018523;
      5'd7:  v = 36'sd7509720;
      5'd8:  v = 36'sd3754917;
      5'd9:  v = 36'sd1877466;
      5'd10: v = 36'sd938734;
      5'd11: v = 36'sd469367;
      5'd12: v = 36'sd234684;
      5'd13: v = 36'sd117342;
      5'd14: v = 36'sd58671;
      5'd15: v = 36'sd29335;
      5'd16: v = 36'sd14668;
      5'd17: v = 36'sd7334;
      5'd18: v = 36'sd3667;
      5'd19: v = 36'sd1833;
      5'd20: v = 36'sd917;
      5'd21: v = 36'sd458;
      5'd22: v = 36'sd229;
      5'd23: v = 36'sd115;
      5'd24: v = 36'sd57;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/core/pat3d_trig.sv
`timescale 1ns / 1ps
`default_nettype none

module pat3d_trig #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int TRIG_BITS       = 18
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [2:0][31:0]            ang_i,
  output logic [2:0][TRIG_BITS+1:0]   cos_o,
  output logic [2:0][TRIG_BITS+1:0]   sin_o,
  output logic                        busy_o
);
  import pat3d_pkg::*;

  localparam int TW    = TRIG_BITS + 2;
  localparam int RED_W = 34;
  localparam int SH    = CORDIC_FRAC - TRIG_BITS;
  localparam longint unsigned FULL = 64'd360 << COORD_FRAC_BITS;
  localparam longint unsigned OFS  = (64'd1 << 31) % FULL;
  localparam logic [RED_W-1:0] FULL_R = RED_W'(FULL);
  localparam logic [RED_W-1:0] OFS_R  = RED_W'(OFS);
  localparam logic [RED_W-1:0] WRAP_R = RED_W'(FULL - OFS);
  localparam logic [4:0] KTOP      = 5'(24 - COORD_FRAC_BITS);
  localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);
  localparam logic signed [ANG_W-1:0] HALF    = ANG_W'(64'd180 << ANG_FRAC);
  localparam logic signed [ANG_W-1:0] QUARTER = ANG_W'(64'd90 << ANG_FRAC);
  localparam logic signed [ANG_W-1:0] FULL_A  = ANG_W'(64'd360 << ANG_FRAC);
  localparam logic signed [XY_W-1:0]  RND     = XY_W'(1) << (SH - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_WRAP   = 3'd2;
  localparam logic [2:0] ST_FOLD   = 3'd3;
  localparam logic [2:0] ST_ITER   = 3'd4;
  localparam logic [2:0] ST_ROUND  = 3'd5;

  logic [2:0]                   state_q, state_d;
  logic [1:0]                   sel_q, sel_d;
  logic [4:0]                   cnt_q, cnt_d;
  logic                         pend_q, pend_d;
  logic                         flip_q, flip_d;
  logic [RED_W-1:0]             acc_q, acc_d;
  logic signed [XY_W-1:0]       x_q, x_d, y_q, y_d;
  logic signed [ANG_W-1:0]      z_q, z_d;
  logic [2:0][TW-1:0]           cos_q, cos_d, sin_q, sin_d;

  logic signed [XY_W-1:0]       dx, dy, xr, yr;
  logic signed [ANG_W-1:0]      atan_v, r24, r1;
  logic [RED_W-1:0]             full_sh;
  logic [1:0]                   sel_nx;
  logic signed [TW-1:0]         cv, sv;

  function automatic logic [RED_W-1:0] load_ang(input logic [31:0] a);
    return {2'b00, ~a[31], a[30:0]};
  endfunction

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    flip_d  = flip_q;
    acc_d   = acc_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    cos_d   = cos_q;
    sin_d   = sin_q;

    dx      = y_q >>> cnt_q;
    dy      = x_q >>> cnt_q;
    atan_v  = atan_deg(cnt_q);
    full_sh = FULL_R << cnt_q;
    r24     = ANG_W'(acc_q) <<< (ANG_FRAC - COORD_FRAC_BITS);
    r1      = (r24 > HALF) ? r24 - FULL_A : r24;
    xr      = (x_q + RND) >>> SH;
    yr      = (y_q + RND) >>> SH;
    cv      = flip_q ? -TW'(xr) : TW'(xr);
    sv      = flip_q ? -TW'(yr) : TW'(yr);
    sel_nx  = sel_q + 2'd1;

    unique case (state_q)
      ST_IDLE: begin
      end
      ST_REDUCE: begin
        if (acc_q >= full_sh) begin
          acc_d = acc_q - full_sh;
        end
        if (cnt_q == 5'd0) begin
          state_d = ST_WRAP;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      ST_WRAP: begin
        acc_d   = (acc_q >= OFS_R) ? acc_q - OFS_R : acc_q + WRAP_R;
        state_d = ST_FOLD;
      end
      ST_FOLD: begin
        if (r1 > QUARTER) begin
          z_d    = r1 - HALF;
          flip_d = 1'b1;
        end else if (r1 < -QUARTER) begin
          z_d    = r1 + HALF;
          flip_d = 1'b1;
        end else begin
          z_d    = r1;
          flip_d = 1'b0;
        end
        x_d     = CORDIC_GAIN;
        y_d     = '0;
        cnt_d   = '0;
        state_d = ST_ITER;
      end
      ST_ITER: begin
        if (z_q[ANG_W-1]) begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + atan_v;
        end else begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - atan_v;
        end
        if (cnt_q == LAST_STEP) begin
          state_d = ST_ROUND;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_ROUND: begin
        cos_d[sel_q] = cv;
        sin_d[sel_q] = sv;
        if (sel_q == 2'd2) begin
          state_d = ST_IDLE;
        end else begin
          sel_d   = sel_nx;
          acc_d   = load_ang(ang_i[sel_nx]);
          cnt_d   = KTOP;
          state_d = ST_REDUCE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // a new angle write restarts the whole sweep
    if (pend_q) begin
      pend_d  = 1'b0;
      sel_d   = 2'd0;
      acc_d   = load_ang(ang_i[0]);
      cnt_d   = KTOP;
      state_d = ST_REDUCE;
    end
    if (start_i) begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flip_q <= flip_d;
    acc_q  <= acc_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    cos_q  <= cos_d;
    sin_q  <= sin_d;
  end

  assign cos_o  = cos_q;
  assign sin_o  = sin_q;
  assign busy_o = pend_q | (state_q != ST_IDLE);

endmodule

`default_nettype wire

### rtl/core/pat3d_scale.sv
`timescale 1ns / 1ps
`default_nettype none

module pat3d_scale #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  scale_i,
  input  logic [2:0][31:0]      factor_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pat3d_pkg::vec_t [2:0] d_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pat3d_pkg::vec_t [2:0] d_o
);
  import pat3d_pkg::*;

  localparam int PW = 65;
  localparam int RW = PW + 1;
  localparam logic signed [RW-1:0] RND  = RW'(1) <<< (COORD_FRAC_BITS - 1);
  localparam logic signed [RW-1:0] VMAX = RW'({1'b0, {(VEC_W-1){1'b1}}});
  localparam logic signed [RW-1:0] VMIN = -VMAX - RW'(1);

  logic                         v1_q, v2_q, rdy1, rdy2;
  logic signed [2:0][PW-1:0]    prod_q, prod_d;
  vec_t [2:0]                   d1_q, d2_q, d2_d;
  logic signed [RW-1:0]         r [3];

  assign rdy2       = !v2_q | out_ready_i;
  assign rdy1       = !v1_q | rdy2;
  assign in_ready_o = rdy1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_d[k] = PW'($signed(d_i[k][32:0])) * PW'($signed(factor_i[k]));
      r[k]      = (RW'($signed(prod_q[k])) + RND) >>> COORD_FRAC_BITS;
      if (!scale_i) begin
        d2_d[k] = d1_q[k];
      end else if (r[k] > VMAX) begin
        d2_d[k] = VMAX[VEC_W-1:0];
      end else if (r[k] < VMIN) begin
        d2_d[k] = VMIN[VEC_W-1:0];
      end else begin
        d2_d[k] = r[k][VEC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      prod_q <= prod_d;
      d1_q   <= d_i;
    end
    if (rdy2) begin
      d2_q <= d2_d;
    end
  end

  assign out_valid_o = v2_q;
  assign d_o         = d2_q;

endmodule

`default_nettype wire

### rtl/core/pat3d_turn.sv
`timescale 1ns / 1ps
`default_nettype none

module pat3d_turn #(
  parameter int TRIG_BITS = 18
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rot_i,
  input  logic signed [TRIG_BITS+1:0]  cos_i,
  input  logic signed [TRIG_BITS+1:0]  sin_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  pat3d_pkg::vec_t              a_i,
  input  pat3d_pkg::vec_t              b_i,
  input  pat3d_pkg::vec_t              k_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output pat3d_pkg::vec_t              a_o,
  output pat3d_pkg::vec_t              b_o,
  output pat3d_pkg::vec_t              k_o
);
  import pat3d_pkg::*;

  localparam int PW = VEC_W + TRIG_BITS + 2;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] RND = SW'(1) <<< (TRIG_BITS - 1);

  logic                   v1_q, v2_q, rdy1, rdy2;
  logic signed [PW-1:0]   ac_q, bs_q, bc_q, as_q;
  vec_t                   a1_q, b1_q, k1_q, a2_q, b2_q, k2_q;
  logic signed [SW-1:0]   na, nb;

  assign rdy2       = !v2_q | out_ready_i;
  assign rdy1       = !v1_q | rdy2;
  assign in_ready_o = rdy1;

  assign na = (SW'(ac_q) - SW'(bs_q) + RND) >>> TRIG_BITS;
  assign nb = (SW'(bc_q) + SW'(as_q) + RND) >>> TRIG_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      ac_q <= PW'(a_i) * PW'(cos_i);
      bs_q <= PW'(b_i) * PW'(sin_i);
      bc_q <= PW'(b_i) * PW'(cos_i);
      as_q <= PW'(a_i) * PW'(sin_i);
      a1_q <= a_i;
      b1_q <= b_i;
      k1_q <= k_i;
    end
    if (rdy2) begin
      a2_q <= rot_i ? na[VEC_W-1:0] : a1_q;
      b2_q <= rot_i ? nb[VEC_W-1:0] : b1_q;
      k2_q <= k1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign a_o         = a2_q;
  assign b_o         = b2_q;
  assign k_o         = k2_q;

endmodule

`default_nettype wire

### rtl/core/point_affine_transform_3d.sv
// point_affine_transform_3d: translate, scale, rotate or pass through one 3d point per item
// input channel in_valid_i/in_ready_o carries in_x_i, in_y_i, in_z_i (q16.16);
// output channel out_valid_o/out_ready_i carries the saturated result.
// config port cfg_we_i/cfg_idx_i/cfg_data_i writes mode, params and center;
// write only while no item is in flight.
// one item per cycle is sustained while the receiver takes results and the
// cordic sequencer is idle. a write to any param register starts the sequencer,
// which computes sine and cosine of the three angles one after another;
// in_ready_o stays low meanwhile. the same sweep runs right after reset,
// so the first item is taken only after that sweep ends.
// every pipeline stage has its own valid bit and moves whenever the stage
// after it is free, so a stalled receiver holds the result in the output
// register and new items keep entering until the pipe fills.
`timescale 1ns / 1ps
`default_nettype none
`include "point_affine_transform_3d_assert.svh"

module point_affine_transform_3d #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int TRIG_BITS       = 18
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  in_x_i,
  input  logic signed [31:0]  in_y_i,
  input  logic signed [31:0]  in_z_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  out_x_o,
  output logic signed [31:0]  out_y_o,
  output logic signed [31:0]  out_z_o
);
  import pat3d_pkg::*;

  localparam int TW = TRIG_BITS + 2;
  localparam int FW = VEC_W + 1;
  localparam logic signed [FW-1:0] SAT_MAX = FW'(32'sh7fffffff);
  localparam logic signed [FW-1:0] SAT_MIN = FW'(-33'sh80000000);

  mode_e                  mode_q;
  logic [2:0][31:0]       param_q, center_q;
  logic                   param_wr, trig_busy;
  logic [2:0][TW-1:0]     cos_w, sin_w;

  function automatic logic signed [31:0] sat32(input logic signed [FW-1:0] v);
    if (v > SAT_MAX) begin
      return 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      return -32'sh80000000;
    end
    return v[31:0];
  endfunction

  // config registers
  assign param_wr = cfg_we_i &&
      (cfg_idx_i == REG_PARAM_X || cfg_idx_i == REG_PARAM_Y || cfg_idx_i == REG_PARAM_Z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_TRANSLATE;
      param_q  <= '0;
      center_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE:     mode_q      <= mode_e'(cfg_data_i[1:0]);
        REG_PARAM_X:  param_q[0]  <= cfg_data_i;
        REG_PARAM_Y:  param_q[1]  <= cfg_data_i;
        REG_PARAM_Z:  param_q[2]  <= cfg_data_i;
        REG_CENTER_X: center_q[0] <= cfg_data_i;
        REG_CENTER_Y: center_q[1] <= cfg_data_i;
        REG_CENTER_Z: center_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pat3d_trig #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .TRIG_BITS      (TRIG_BITS)
  ) u_trig (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(param_wr),
    .ang_i  (param_q),
    .cos_o  (cos_w),
    .sin_o  (sin_w),
    .busy_o (trig_busy)
  );

  // stage 0: offset by delta or center, or pass unchanged in pass mode
  logic           s0_v_q, s0_rdy, sc_rdy;
  vec_t [2:0]     s0_q, s0_d, in_v;

  assign in_v[0] = VEC_W'(in_x_i);
  assign in_v[1] = VEC_W'(in_y_i);
  assign in_v[2] = VEC_W'(in_z_i);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unique case (mode_q)
        MODE_TRANSLATE:          s0_d[k] = in_v[k] + VEC_W'($signed(param_q[k]));
        MODE_SCALE, MODE_ROTATE: s0_d[k] = in_v[k] - VEC_W'($signed(center_q[k]));
        default:                 s0_d[k] = in_v[k];
      endcase
    end
  end

  assign s0_rdy     = !s0_v_q | sc_rdy;
  assign in_ready_o = s0_rdy & !trig_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (s0_rdy) begin
      s0_v_q <= in_valid_i & !trig_busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_rdy) begin
      s0_q <= s0_d;
    end
  end

  // scale about center
  logic           sc_v, tx_rdy;
  vec_t [2:0]     sc_d;

  pat3d_scale #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .scale_i    (mode_q == MODE_SCALE),
    .factor_i   (param_q),
    .in_valid_i (s0_v_q),
    .in_ready_o (sc_rdy),
    .d_i        (s0_q),
    .out_valid_o(sc_v),
    .out_ready_i(tx_rdy),
    .d_o        (sc_d)
  );

  // rotations about x, then y, then z
  logic rot;
  logic tx_v, ty_v, tz_v, ty_rdy, tz_rdy, fin_rdy;
  vec_t tx_y, tx_z, tx_x, ty_x, ty_z, ty_y, tz_x, tz_y, tz_z;

  assign rot = (mode_q == MODE_ROTATE);

  pat3d_turn #(.TRIG_BITS(TRIG_BITS)) u_turn_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rot_i      (rot),
    .cos_i      ($signed(cos_w[0])),
    .sin_i      ($signed(sin_w[0])),
    .in_valid_i (sc_v),
    .in_ready_o (tx_rdy),
    .a_i        (sc_d[1]),
    .b_i        (sc_d[2]),
    .k_i        (sc_d[0]),
    .out_valid_o(tx_v),
    .out_ready_i(ty_rdy),
    .a_o        (tx_y),
    .b_o        (tx_z),
    .k_o        (tx_x)
  );

  pat3d_turn #(.TRIG_BITS(TRIG_BITS)) u_turn_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rot_i      (rot),
    .cos_i      ($signed(cos_w[1])),
    .sin_i      ($signed(sin_w[1])),
    .in_valid_i (tx_v),
    .in_ready_o (ty_rdy),
    .a_i        (tx_x),
    .b_i        (tx_z),
    .k_i        (tx_y),
    .out_valid_o(ty_v),
    .out_ready_i(tz_rdy),
    .a_o        (ty_x),
    .b_o        (ty_z),
    .k_o        (ty_y)
  );

  pat3d_turn #(.TRIG_BITS(TRIG_BITS)) u_turn_z (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rot_i      (rot),
    .cos_i      ($signed(cos_w[2])),
    .sin_i      ($signed(sin_w[2])),
    .in_valid_i (ty_v),
    .in_ready_o (tz_rdy),
    .a_i        (ty_x),
    .b_i        (ty_y),
    .k_i        (ty_z),
    .out_valid_o(tz_v),
    .out_ready_i(fin_rdy),
    .a_o        (tz_x),
    .b_o        (tz_y),
    .k_o        (tz_z)
  );

  // output stage: add center back and saturate
  logic                 out_v_q;
  logic signed [31:0]   ox_q, oy_q, oz_q;
  logic signed [FW-1:0] ctr_x, ctr_y, ctr_z;
  logic                 add_ctr;

  assign add_ctr = (mode_q == MODE_SCALE) || (mode_q == MODE_ROTATE);
  assign ctr_x   = add_ctr ? FW'($signed(center_q[0])) : '0;
  assign ctr_y   = add_ctr ? FW'($signed(center_q[1])) : '0;
  assign ctr_z   = add_ctr ? FW'($signed(center_q[2])) : '0;
  assign fin_rdy = !out_v_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (fin_rdy) begin
      out_v_q <= tz_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_rdy) begin
      ox_q <= sat32(FW'(tz_x) + ctr_x);
      oy_q <= sat32(FW'(tz_y) + ctr_y);
      oz_q <= sat32(FW'(tz_z) + ctr_z);
    end
  end

  assign out_valid_o = out_v_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_z_o     = oz_q;

  `PAT_ASSERT(a_angle_write_starts_trig, param_wr |=> trig_busy, "angle write did not start trig")
  `PAT_ASSERT(a_accept_fills_stage0, in_valid_i && in_ready_o |=> s0_v_q, "accepted item lost")
  `PAT_ASSERT_ALWAYS(a_busy_blocks_input, trig_busy |-> !in_ready_o, "item taken during trig")

endmodule

`default_nettype wire

### tb/tb_point_affine_transform_3d.sv
`timescale 1ns / 1ps

module tb_point_affine_transform_3d;
  import pat3d_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] in_x_i = '0, in_y_i = '0, in_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] out_x_o, out_y_o, out_z_o;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  point_t pending_points[$];
  int mismatch_count = 0;
  int points_sent = 0;
  int points_checked = 0;
  longint cycle_count = 0;
  bit stall_enable = 1'b1;

  mode_e cur_mode;
  longint cur_param[3];
  longint cur_center[3];

  localparam longint ATAN_Q24[25] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
    117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57};

  point_transform_3d_unused_guard guard_unused();

  point_affine_transform_3d dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("timeout at %0t", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_drop(longint v, int s);
    return floor_shift(v + (longint'(1) <<< (s - 1)), s);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  task automatic angle_trig(input longint ang, output longint c, output longint s);
    longint full, half, quarter, r, x, y, z, dx, dy;
    bit flip;
    full = longint'(360) <<< 16;
    half = longint'(180) <<< 24;
    quarter = longint'(90) <<< 24;
    flip = 1'b0;
    r = ang % full;
    if (r < 0) r += full;
    r = r <<< 8;
    if (r > half) r -= 2 * half;
    if (r > quarter) begin
      r -= half;
      flip = 1'b1;
    end else if (r < -quarter) begin
      r += half;
      flip = 1'b1;
    end
    x = 652032874;
    y = 0;
    z = r;
    for (int i = 0; i < 25; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_Q24[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_Q24[i];
      end
    end
    x = round_drop(x, 12);
    y = round_drop(y, 12);
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
  endtask

  task automatic rotate_pair(inout longint a, inout longint b, input longint c,
                             input longint s);
    longint na, nb;
    na = round_drop(a * c - b * s, 18);
    nb = round_drop(b * c + a * s, 18);
    a = na;
    b = nb;
  endtask

  task automatic transform_point(input point_t p, output point_t r);
    longint v[3];
    longint c, s;
    v[0] = p.x;
    v[1] = p.y;
    v[2] = p.z;
    case (cur_mode)
      MODE_TRANSLATE: begin
        for (int k = 0; k < 3; k++) v[k] += cur_param[k];
      end
      MODE_SCALE: begin
        for (int k = 0; k < 3; k++)
          v[k] = round_drop((v[k] - cur_center[k]) * cur_param[k], 16) + cur_center[k];
      end
      MODE_ROTATE: begin
        for (int k = 0; k < 3; k++) v[k] -= cur_center[k];
        angle_trig(cur_param[0], c, s);
        rotate_pair(v[1], v[2], c, s);
        angle_trig(cur_param[1], c, s);
        rotate_pair(v[0], v[2], c, s);
        angle_trig(cur_param[2], c, s);
        rotate_pair(v[0], v[1], c, s);
        for (int k = 0; k < 3; k++) v[k] += cur_center[k];
      end
      default: ;
    endcase
    r.x = clamp32(v[0]);
    r.y = clamp32(v[1]);
    r.z = clamp32(v[2]);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_MODE: cur_mode = mode_e'(data[1:0]);
      REG_PARAM_X: cur_param[0] = longint'(signed'(data));
      REG_PARAM_Y: cur_param[1] = longint'(signed'(data));
      REG_PARAM_Z: cur_param[2] = longint'(signed'(data));
      REG_CENTER_X: cur_center[0] = longint'(signed'(data));
      REG_CENTER_Y: cur_center[1] = longint'(signed'(data));
      REG_CENTER_Z: cur_center[2] = longint'(signed'(data));
      default: ;
    endcase
  endtask

  // drop valid and wait until every expected result has come
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (pending_points.size() == 0);
  endtask

  task automatic setup(input mode_e m, input logic [31:0] px, input logic [31:0] py,
                       input logic [31:0] pz, input logic [31:0] cx,
                       input logic [31:0] cy, input logic [31:0] cz);
    drain();
    repeat (20) @(negedge clk_i);
    write_reg(REG_MODE, 32'(m));
    write_reg(REG_PARAM_X, px);
    write_reg(REG_PARAM_Y, py);
    write_reg(REG_PARAM_Z, pz);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
  endtask

  task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
    point_t p, r;
    @(negedge clk_i);
    if (stall_enable && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_x_i = x;
    in_y_i = y;
    in_z_i = z;
    do @(posedge clk_i); while (!in_ready_o);
    p.x = x;
    p.y = y;
    p.z = z;
    transform_point(p, r);
    pending_points.push_back(r);
    points_sent++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h80000000 + $urandom_range(0, 3);
      1: return 32'h7fffffff - $urandom_range(0, 3);
      2: return 32'($signed($urandom_range(0, 200000)) - 100000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_factor();
    case ($urandom_range(0, 3))
      0: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      1: return rand_coord();
      default: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
    endcase
  endfunction

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(0, 4))
      0: return 32'($signed($urandom_range(0, 8)) * 90) <<< 16;
      1: return $urandom;
      default: return 32'($signed($urandom_range(0, 720 << 8)) - (360 << 8)) <<< 8;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h", $time, out_x_o, out_y_o,
                 out_z_o);
        mismatch_count++;
      end else begin
        point_t e;
        e = pending_points.pop_front();
        points_checked++;
        if (out_x_o !== e.x || out_y_o !== e.y || out_z_o !== e.z) begin
          $display("%0t: expected x=%h y=%h z=%h actual x=%h y=%h z=%h", $time,
                   e.x, e.y, e.z, out_x_o, out_y_o, out_z_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_enable && $urandom_range(0, 7) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
    end
  end

  task automatic test_translate();
    setup(MODE_TRANSLATE, 32'h7fffffff, 32'h80000000, 32'h00010000, 0, 0, 0);
    send_point(32'h7fffffff, 32'h80000000, 32'h0);
    send_point(32'h80000000, 32'h7fffffff, 32'hffffffff);
    send_point(0, 0, 0);
    for (int i = 0; i < 300; i++) begin
      if (i % 100 == 0)
        setup(MODE_TRANSLATE, rand_coord(), rand_coord(), rand_coord(), 0, 0, 0);
      send_point(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  task automatic test_scale();
    setup(MODE_SCALE, 32'h7fffffff, 32'h80000000, 32'h00008000,
          32'h80000000, 32'h7fffffff, 32'h00000001);
    send_point(32'h7fffffff, 32'h80000000, 32'h00000003);
    send_point(32'h80000000, 32'h7fffffff, 32'hfffffffd);
    send_point(0, 0, 0);
    for (int i = 0; i < 450; i++) begin
      if (i % 90 == 0)
        setup(MODE_SCALE, rand_factor(), rand_factor(), rand_factor(),
              rand_coord(), rand_coord(), rand_coord());
      send_point(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  task automatic test_rotate();
    setup(MODE_ROTATE, 32'd90 << 16, 32'h80000000, 32'h7fffffff, 0, 0, 0);
    send_point(32'h7fffffff, 32'h80000000, 32'h00010000);
    send_point(32'h80000000, 32'h7fffffff, 32'h7fffffff);
    setup(MODE_ROTATE, 32'(-180) <<< 16, 32'd270 << 16, 32'd45 << 16,
          32'h00100000, 32'hfff00000, 32'h7fffffff);
    send_point(32'h80000000, 32'h00050000, 32'h0);
    send_point(0, 0, 0);
    for (int i = 0; i < 800; i++) begin
      if (i % 80 == 0)
        setup(MODE_ROTATE, rand_angle(), rand_angle(), rand_angle(),
              rand_coord(), rand_coord(), rand_coord());
      if (i == 400) drain();
      send_point(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  task automatic test_passthrough();
    setup(MODE_PASS, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    send_point(32'h7fffffff, 32'h80000000, 32'h0);
    for (int i = 0; i < 100; i++) send_point(rand_coord(), rand_coord(), rand_coord());
    drain();
    write_reg(3'd7, $urandom);
  endtask

  task automatic test_full_rate();
    setup(MODE_SCALE, 32'h00018000, 32'hffff0000, 32'h00020000, 0, 32'h100, 0);
    stall_enable = 1'b0;
    for (int i = 0; i < 150; i++) send_point(rand_coord(), rand_coord(), rand_coord());
  endtask

  initial begin
    cur_mode = MODE_TRANSLATE;
    cur_param = '{0, 0, 0};
    cur_center = '{0, 0, 0};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    send_point(32'h00010000, 32'h80000000, 32'h7fffffff);
    test_translate();
    test_scale();
    test_rotate();
    test_passthrough();
    test_full_rate();
    drain();
    repeat (30) @(negedge clk_i);
    $display("sent %0d points, checked %0d results", points_sent, points_checked);
    $display("covered translate, scale, rotate and passthrough modes with saturation");
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

module point_transform_3d_unused_guard;
endmodule
